### rtl/rae_pkg.sv
package rae_pkg;

   // Parser position within one packet.
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TYPE,
      PH_LEN,
      PH_VALUE,
      PH_STOP
   } phase_type;

   // Header size in bytes and its counter width.
   localparam logic [4:0] HEADER_BYTES = 5'd20;

   // Attribute type codes.
   localparam logic [7:0] ATTR_USER_NAME = 8'd1;
   localparam logic [7:0] ATTR_FRAMED_IP = 8'd8;
   localparam logic [7:0] ATTR_CALLING_ID = 8'd31;
   localparam logic [7:0] ATTR_ENDPOINT = 8'd66;

   // Length rules.
   localparam logic [7:0] LEN_MIN = 8'd3;
   localparam logic [7:0] LEN_TLV_HEAD = 8'd2;
   localparam logic [7:0] LEN_FRAMED_IP = 8'd6;
   localparam logic [7:0] LEN_MAC = 8'd14;
   localparam logic [3:0] MAC_LAST_POS = 4'd11;

   // Character constants for MAC formatting.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Result kind codes.
   localparam logic [1:0] KIND_USER = 2'd0;
   localparam logic [1:0] KIND_IPV4 = 2'd1;
   localparam logic [1:0] KIND_MAC = 2'd2;
   localparam logic [1:0] KIND_ENDPOINT = 2'd3;

   // One classified word passed from the parser to the output stage.
   // With colon set it expands to the character followed by a colon.
   typedef struct packed {
      logic       colon;
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       bad;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

### rtl/rae_front.sv
module rae_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 packet_end,
   output logic                 cmd_valid,
   output rae_pkg::cmd_type     cmd
);

   rae_pkg::phase_type phase_ff, phase_in;
   logic [4:0] header_left_ff, header_left_in;
   logic [7:0] attr_code_ff, attr_code_in;
   logic [7:0] value_left_ff, value_left_in;
   logic [3:0] mac_pos_ff, mac_pos_in;
   logic       emit_ff, emit_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= rae_pkg::PH_HEADER;
         header_left_ff <= rae_pkg::HEADER_BYTES;
         attr_code_ff   <= '0;
         value_left_ff  <= '0;
         mac_pos_ff     <= '0;
         emit_ff        <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         header_left_ff <= header_left_in;
         attr_code_ff   <= attr_code_in;
         value_left_ff  <= value_left_in;
         mac_pos_ff     <= mac_pos_in;
         emit_ff        <= emit_in;
      end
   end

   // Next state and the classified word for the accepted byte.
   always_comb begin
      logic [7:0] left_dec;
      logic       done;
      logic [7:0] lowered;
      logic       colon;
      logic       trunc;

      phase_in       = phase_ff;
      header_left_in = header_left_ff;
      attr_code_in   = attr_code_ff;
      value_left_in  = value_left_ff;
      mac_pos_in     = mac_pos_ff;
      emit_in        = emit_ff;
      cmd_valid      = 1'b0;
      cmd            = '0;

      left_dec = (value_left_ff != 8'd0) ? value_left_ff - 8'd1 : 8'd0;
      done     = (left_dec == 8'd0);
      lowered  = (data_byte >= rae_pkg::CHAR_UPPER_A && data_byte <= rae_pkg::CHAR_UPPER_Z)
                 ? data_byte + rae_pkg::CASE_OFFSET : data_byte;
      colon    = mac_pos_ff[0] && (mac_pos_ff < rae_pkg::MAC_LAST_POS);
      trunc    = packet_end && !done;

      unique case (phase_ff)
         rae_pkg::PH_HEADER: begin
            if (header_left_ff > 5'd1) begin
               header_left_in = header_left_ff - 5'd1;
            end else begin
               header_left_in = '0;
               phase_in       = rae_pkg::PH_TYPE;
            end
         end
         rae_pkg::PH_TYPE: begin
            attr_code_in = data_byte;
            phase_in     = rae_pkg::PH_LEN;
         end
         rae_pkg::PH_LEN: begin
            if (data_byte < rae_pkg::LEN_MIN ||
                (attr_code_ff == rae_pkg::ATTR_FRAMED_IP &&
                 data_byte != rae_pkg::LEN_FRAMED_IP)) begin
               phase_in = rae_pkg::PH_STOP;
            end else begin
               value_left_in = data_byte - rae_pkg::LEN_TLV_HEAD;
               mac_pos_in    = '0;
               emit_in       = (attr_code_ff == rae_pkg::ATTR_USER_NAME) ||
                               (attr_code_ff == rae_pkg::ATTR_FRAMED_IP) ||
                               (attr_code_ff == rae_pkg::ATTR_ENDPOINT) ||
                               (attr_code_ff == rae_pkg::ATTR_CALLING_ID &&
                                data_byte == rae_pkg::LEN_MAC);
               phase_in      = rae_pkg::PH_VALUE;
            end
         end
         rae_pkg::PH_VALUE: begin
            value_left_in = left_dec;
            if (emit_ff) begin
               cmd_valid = 1'b1;
               cmd.bad   = trunc;
               if (attr_code_ff == rae_pkg::ATTR_CALLING_ID) begin
                  cmd.kind   = rae_pkg::KIND_MAC;
                  cmd.data   = lowered;
                  cmd.colon  = colon;
                  cmd.last   = done || trunc;
                  mac_pos_in = mac_pos_ff + 4'd1;
               end else begin
                  cmd.kind = (attr_code_ff == rae_pkg::ATTR_USER_NAME) ? rae_pkg::KIND_USER :
                             (attr_code_ff == rae_pkg::ATTR_FRAMED_IP) ? rae_pkg::KIND_IPV4 :
                             rae_pkg::KIND_ENDPOINT;
                  cmd.data = data_byte;
                  cmd.last = done || trunc;
               end
            end
            if (done) begin
               phase_in = rae_pkg::PH_TYPE;
            end
         end
         rae_pkg::PH_STOP: begin
         end
         default: begin
            phase_in = rae_pkg::PH_STOP;
         end
      endcase

      // The final byte of a packet returns the parser to its idle state.
      if (packet_end) begin
         phase_in       = rae_pkg::PH_HEADER;
         header_left_in = rae_pkg::HEADER_BYTES;
         attr_code_in   = '0;
         value_left_in  = '0;
         mac_pos_in     = '0;
         emit_in        = 1'b0;
      end

      // Nothing changes without an accepted byte.
      if (!accept) begin
         phase_in       = phase_ff;
         header_left_in = header_left_ff;
         attr_code_in   = attr_code_ff;
         value_left_in  = value_left_ff;
         mac_pos_in     = mac_pos_ff;
         emit_in        = emit_ff;
         cmd_valid      = 1'b0;
      end
   end

endmodule

### rtl/rae_fifo.sv
module rae_fifo #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  rae_pkg::cmd_type wr_cmd,
   input  logic             rd_en,
   output rae_pkg::cmd_type rd_cmd,
   output logic             is_empty,
   output logic             is_full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rae_pkg::cmd_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign rd_cmd   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

### rtl/rae_back.sv
module rae_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  rae_pkg::cmd_type q_head,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [1:0]       attr_kind,
   output logic [7:0]       out_byte,
   output logic             attr_last,
   output logic             attr_bad
);

   logic       valid_ff, valid_in;
   logic       half_ff, half_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       bad_ff, bad_in;
   logic       load;

   assign empty     = !valid_ff;
   assign attr_kind = kind_ff;
   assign out_byte  = byte_ff;
   assign attr_last = last_ff;
   assign attr_bad  = bad_ff;

   // The output word register refills when it is free or being taken.
   assign load = !valid_ff || pop;

   // Expand a queued entry into one or two result words.
   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            kind_in = q_head.kind;
            if (q_head.colon && !half_ff) begin
               byte_in = q_head.data;
               last_in = 1'b0;
               bad_in  = 1'b0;
               half_in = 1'b1;
            end else if (q_head.colon) begin
               byte_in = rae_pkg::CHAR_COLON;
               last_in = q_head.last;
               bad_in  = q_head.bad;
               half_in = 1'b0;
               q_pop   = 1'b1;
            end else begin
               byte_in = q_head.data;
               last_in = q_head.last;
               bad_in  = q_head.bad;
               q_pop   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   // Result payload carries no reset.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

endmodule

### rtl/radius_attribute_extractor_top.sv
// RADIUS attribute extractor.
// Input channel: one packet byte per word on req_data_byte, with req_packet_end
// high on the final byte of each packet. A word is taken when push is high and
// full is low. The first 20 bytes are skipped as header; the rest is walked as
// type/length/value attributes.
// Result channel: a word is shown while empty is low and taken when pop is high.
// Each word carries the attribute kind, one value byte or MAC character, a last
// flag and a bad flag that marks an attribute cut off by the packet end.
// Each entry passes through the queue and then the result register on its way out.
// Input bytes are taken one per cycle while full is low; a MAC byte that is
// followed by a colon yields two result words, so the sustained rate is set by
// the single result register draining one word per cycle while pop is high.
// A queue of QUEUE_DEPTH words (2 or more) sits between parser and output; full
// rises when it fills, so a stalled receiver stops the input once the queue holds
// that many entries, and no word is lost.
// Reset clears the parser to the start of a packet and empties the queue and
// the result register; full is low in the cycle after reset.
module radius_attribute_extractor_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_packet_end,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_attr_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_attr_last,
   output logic       rsp_attr_bad
);

   logic             accept;
   logic             cmd_valid;
   rae_pkg::cmd_type cmd;
   rae_pkg::cmd_type q_head;
   logic             q_empty;
   logic             q_full;
   logic             q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   // Parser: classifies each byte and produces at most one queued entry.
   rae_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .packet_end (req_packet_end),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   // Decoupling queue between parser and output stage.
   rae_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_valid),
      .wr_cmd   (cmd),
      .rd_en    (q_pop),
      .rd_cmd   (q_head),
      .is_empty (q_empty),
      .is_full  (q_full)
   );

   // Output stage: formats entries into result words.
   rae_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .pop       (pop),
      .empty     (empty),
      .attr_kind (rsp_attr_kind),
      .out_byte  (rsp_out_byte),
      .attr_last (rsp_attr_last),
      .attr_bad  (rsp_attr_bad)
   );

endmodule

### rtl/rae_checker.sv
module rae_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_attr_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_attr_last,
   input logic       rsp_attr_bad
);

   // Reset leaves no result word waiting.
   assert property (@(posedge clock) reset |=> empty)
      else $error("result word present after reset");

   // Reset leaves the input side open.
   assert property (@(posedge clock) reset |=> !full)
      else $error("input blocked after reset");

   // A bad mark only ever closes an attribute.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (!rsp_attr_bad || rsp_attr_last))
      else $error("bad mark on a word that is not last");

   // A stalled result word holds still.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_attr_kind) &&
                            $stable(rsp_attr_last) && $stable(rsp_attr_bad)))
      else $error("stalled result word changed");

endmodule

bind radius_attribute_extractor_top rae_checker u_rae_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_attr_kind (rsp_attr_kind),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_attr_last (rsp_attr_last),
   .rsp_attr_bad  (rsp_attr_bad)
);

### test/radius_attribute_extractor_top_tb.sv
module radius_attribute_extractor_top_tb;

   // Cycles without any accepted word before the run is declared hung.
   localparam int STALL_LIMIT = 5000;
   // Input words that the random part aims for.
   localparam int PARSED_TARGET = 610;
   // Cycles to wait after the last expected word, as a margin.
   localparam int TAIL_CYCLES = 8;

   // One word on the result channel.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       bad;
   } attr_word_type;

   // Tracks the parser state of the block and holds the words it must produce.
   class attr_scoreboard;
      rae_pkg::phase_type phase = rae_pkg::PH_HEADER;
      logic [4:0]      header_left = rae_pkg::HEADER_BYTES;
      logic [7:0]      code = '0;
      logic [7:0]      value_left = '0;
      logic [3:0]      mac_pos = '0;
      logic            emit = 1'b0;
      attr_word_type   pending[$];
      int unsigned     mismatches = 0;

      function void restart();
         phase = rae_pkg::PH_HEADER;
         header_left = rae_pkg::HEADER_BYTES;
         code = '0;
         value_left = '0;
         mac_pos = '0;
         emit = 1'b0;
      endfunction

      function logic [1:0] kind_for(logic [7:0] c);
         if (c == rae_pkg::ATTR_USER_NAME) return rae_pkg::KIND_USER;
         if (c == rae_pkg::ATTR_FRAMED_IP) return rae_pkg::KIND_IPV4;
         if (c == rae_pkg::ATTR_CALLING_ID) return rae_pkg::KIND_MAC;
         return rae_pkg::KIND_ENDPOINT;
      endfunction

      function attr_word_type make_word(logic [7:0] data, logic last);
         attr_word_type w;
         w.kind = kind_for(code);
         w.data = data;
         w.last = last;
         w.bad = 1'b0;
         return w;
      endfunction

      // Advances the parser by one accepted byte and queues the words it yields.
      function void note_byte(logic [7:0] b, logic eop);
         attr_word_type words[$];
         attr_word_type w;
         logic          done;
         logic [7:0]    ch;
         case (phase)
            rae_pkg::PH_HEADER: begin
               if (header_left > 5'd1) begin
                  header_left = header_left - 5'd1;
               end else begin
                  header_left = '0;
                  phase = rae_pkg::PH_TYPE;
               end
            end
            rae_pkg::PH_TYPE: begin
               code = b;
               phase = rae_pkg::PH_LEN;
            end
            rae_pkg::PH_LEN: begin
               if (b < rae_pkg::LEN_MIN ||
                   (code == rae_pkg::ATTR_FRAMED_IP && b != rae_pkg::LEN_FRAMED_IP)) begin
                  phase = rae_pkg::PH_STOP;
               end else begin
                  value_left = b - rae_pkg::LEN_TLV_HEAD;
                  mac_pos = '0;
                  emit = code == rae_pkg::ATTR_USER_NAME || code == rae_pkg::ATTR_FRAMED_IP ||
                         code == rae_pkg::ATTR_ENDPOINT ||
                         (code == rae_pkg::ATTR_CALLING_ID && b == rae_pkg::LEN_MAC);
                  phase = rae_pkg::PH_VALUE;
               end
            end
            rae_pkg::PH_VALUE: begin
               if (value_left > 8'd0) value_left = value_left - 8'd1;
               done = value_left == 8'd0;
               if (emit && code == rae_pkg::ATTR_CALLING_ID) begin
                  // Lower the letters and put a colon after every odd position but the last.
                  ch = (b >= rae_pkg::CHAR_UPPER_A && b <= rae_pkg::CHAR_UPPER_Z) ?
                       b + rae_pkg::CASE_OFFSET : b;
                  if (mac_pos[0] && mac_pos < rae_pkg::MAC_LAST_POS) begin
                     words.push_back(make_word(ch, 1'b0));
                     words.push_back(make_word(rae_pkg::CHAR_COLON, 1'b0));
                  end else begin
                     words.push_back(make_word(ch, done));
                  end
                  mac_pos = mac_pos + 4'd1;
               end else if (emit) begin
                  words.push_back(make_word(b, done));
               end
               if (done) phase = rae_pkg::PH_TYPE;
            end
            default: begin
               // Parsing has stopped; bytes are dropped until the packet ends.
            end
         endcase

         // A value cut short by the packet end closes with the bad mark.
         if (eop && words.size() > 0 && phase == rae_pkg::PH_VALUE && value_left > 8'd0) begin
            w = words.pop_back();
            w.last = 1'b1;
            w.bad = 1'b1;
            words.push_back(w);
         end
         foreach (words[i]) pending.push_back(words[i]);
         if (eop) restart();
      endfunction

      task report(string msg);
         mismatches++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      // Compares one accepted word with the oldest expected one.
      task check_word(logic [1:0] kind, logic [7:0] data, logic last, logic bad);
         attr_word_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word kind %0d data %02h last %0b bad %0b",
                             kind, data, last, bad));
         end else begin
            want = pending.pop_front();
            if (kind !== want.kind)
               report($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (data !== want.data)
               report($sformatf("data %02h, expected %02h", data, want.data));
            if (last !== want.last)
               report($sformatf("last %0b, expected %0b", last, want.last));
            if (bad !== want.bad)
               report($sformatf("bad %0b, expected %0b", bad, want.bad));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_data_byte = '0;
   logic       req_packet_end = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [1:0] rsp_attr_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_attr_last;
   logic       rsp_attr_bad;

   attr_scoreboard sb = new;

   logic [7:0] packet_bytes[$];
   int         burst_left = 0;
   bit         no_gaps = 1'b0;
   int         idle_count = 0;
   logic [9:0] rx_tick = '0;
   logic [1:0] rx_mode = '0;

   radius_attribute_extractor_top u_top (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_packet_end (req_packet_end),
      .empty          (empty),
      .pop            (pop),
      .rsp_attr_kind  (rsp_attr_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_attr_last  (rsp_attr_last),
      .rsp_attr_bad   (rsp_attr_bad)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both handshakes are observed at the rising edge; the watchdog runs alongside.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_byte(req_data_byte, req_packet_end);
         if (pop && !empty) begin
            sb.check_word(rsp_attr_kind, rsp_out_byte, rsp_attr_last, rsp_attr_bad);
         end
         if ((push && !full) || (pop && !empty)) begin
            idle_count = 0;
         end else begin
            idle_count++;
            if (idle_count >= STALL_LIMIT) begin
               $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
               $display("** radius_attribute_extractor_top: FAILED **");
               $finish;
            end
         end
      end
   end

   // The receiver switches between steady popping, random stalls and long stalls.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         rx_tick <= rx_tick + 10'd1;
         if (rx_tick[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
         case (rx_mode)
            2'd0: pop <= 1'b1;
            2'd1: pop <= 1'($urandom_range(0, 1));
            2'd2: pop <= $urandom_range(0, 7) != 0;
            default: pop <= rx_tick[4:0] < 5'd4;
         endcase
      end
   end

   // Drives one word and holds it until the block takes it.
   task automatic send_byte(input logic [7:0] b, input logic eop);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = no_gaps ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      push <= 1'b1;
      req_data_byte <= b;
      req_packet_end <= eop;
      do @(posedge clock); while (full);
      burst_left--;
   endtask

   task automatic send_packet();
      foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
      packet_bytes.delete();
   endtask

   // Stops sending until every expected word has been taken.
   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic void add_header(bit extremes);
      for (int i = 0; i < rae_pkg::HEADER_BYTES; i++) begin
         if (extremes) packet_bytes.push_back(i[0] ? 8'hFF : 8'h00);
         else packet_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // MAC values favor letters and the bytes right around the upper-case range.
   function automatic logic [7:0] value_byte(logic [7:0] c);
      if (c != rae_pkg::ATTR_CALLING_ID) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(rae_pkg::CHAR_UPPER_A, rae_pkg::CHAR_UPPER_Z));
         1: return $urandom_range(0, 1) ? rae_pkg::CHAR_UPPER_A - 8'd1 :
                                          rae_pkg::CHAR_UPPER_Z + 8'd1;
         2: return 8'($urandom_range(8'h30, 8'h39));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_attr(logic [7:0] c, logic [7:0] len);
      packet_bytes.push_back(c);
      packet_bytes.push_back(len);
      if (len >= rae_pkg::LEN_MIN) begin
         for (int i = 0; i < len - rae_pkg::LEN_TLV_HEAD; i++) begin
            packet_bytes.push_back(value_byte(c));
         end
      end
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 9))
         0, 1: return rae_pkg::ATTR_USER_NAME;
         2: return rae_pkg::ATTR_FRAMED_IP;
         3, 4, 5: return rae_pkg::ATTR_CALLING_ID;
         6, 7: return rae_pkg::ATTR_ENDPOINT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly legal lengths, with short, mismatched and very long ones mixed in.
   function automatic logic [7:0] pick_len(logic [7:0] c);
      int r;
      logic [7:0] len;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'($urandom_range(0, 2));
      if (c == rae_pkg::ATTR_FRAMED_IP) begin
         if (r != 1) return rae_pkg::LEN_FRAMED_IP;
         len = 8'($urandom_range(3, 255));
         return (len == rae_pkg::LEN_FRAMED_IP) ? len + 8'd1 : len;
      end
      if (c == rae_pkg::ATTR_CALLING_ID) begin
         return (r <= 2) ? 8'($urandom_range(3, 20)) : rae_pkg::LEN_MAC;
      end
      if (r == 1 && $urandom_range(0, 3) == 0) return 8'($urandom_range(3, 255));
      return 8'($urandom_range(3, 18));
   endfunction

   function automatic void build_random_packet();
      int shape;
      int keep;
      logic [7:0] c;
      add_header(1'b0);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         // Noise after the header.
         repeat ($urandom_range(1, 30)) packet_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (shape == 1) begin
         // Packet that ends inside the header.
         keep = $urandom_range(1, rae_pkg::HEADER_BYTES);
         while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
      end else begin
         repeat ($urandom_range(1, 6)) begin
            c = pick_code();
            add_attr(c, pick_len(c));
         end
         // A quarter of these attribute packets are cut at a random point.
         if ($urandom_range(0, 3) == 0) begin
            keep = $urandom_range(rae_pkg::HEADER_BYTES + 1, packet_bytes.size());
            while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
         end
      end
   endfunction

   initial begin
      logic [7:0] mac_text[12];
      int parsed;
      mac_text = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40, 8'h5B,
                   8'h30, 8'h39, 8'h00, 8'hFF, 8'h62, 8'h43};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every attribute kind, an ignored MAC length, an unknown type, and a bad
      // framed-IP length that stops parsing.
      add_header(1'b1);
      packet_bytes.push_back(rae_pkg::ATTR_USER_NAME);
      packet_bytes.push_back(rae_pkg::LEN_MIN);
      packet_bytes.push_back(8'hFF);
      packet_bytes.push_back(rae_pkg::ATTR_CALLING_ID);
      packet_bytes.push_back(rae_pkg::LEN_MAC);
      foreach (mac_text[i]) packet_bytes.push_back(mac_text[i]);
      packet_bytes.push_back(rae_pkg::ATTR_FRAMED_IP);
      packet_bytes.push_back(rae_pkg::LEN_FRAMED_IP);
      packet_bytes.push_back(8'h00);
      packet_bytes.push_back(8'hFF);
      packet_bytes.push_back(8'h80);
      packet_bytes.push_back(8'h01);
      add_attr(rae_pkg::ATTR_ENDPOINT, 8'd4);
      add_attr(rae_pkg::ATTR_CALLING_ID, rae_pkg::LEN_MIN);
      add_attr(8'd200, rae_pkg::LEN_MIN);
      add_attr(rae_pkg::ATTR_FRAMED_IP, 8'd7);
      packet_bytes.push_back(8'h01);
      packet_bytes.push_back(8'h05);
      send_packet();

      // User name cut by the packet end.
      add_header(1'b0);
      packet_bytes.push_back(rae_pkg::ATTR_USER_NAME);
      packet_bytes.push_back(8'd10);
      repeat (3) packet_bytes.push_back(value_byte(rae_pkg::ATTR_USER_NAME));
      send_packet();

      // Packet ends in the header, on a type byte, and on a length byte.
      repeat (5) packet_bytes.push_back(8'h5A);
      send_packet();
      add_header(1'b0);
      packet_bytes.push_back(rae_pkg::ATTR_ENDPOINT);
      send_packet();
      add_header(1'b0);
      packet_bytes.push_back(rae_pkg::ATTR_ENDPOINT);
      packet_bytes.push_back(8'd9);
      send_packet();

      // Lengths of zero and two stop parsing.
      add_header(1'b0);
      add_attr(rae_pkg::ATTR_USER_NAME, 8'd0);
      packet_bytes.push_back(8'h33);
      send_packet();
      add_header(1'b0);
      add_attr(rae_pkg::ATTR_ENDPOINT, rae_pkg::LEN_TLV_HEAD);
      packet_bytes.push_back(8'h44);
      send_packet();

      // MAC text cut right on a character that carries a colon.
      add_header(1'b0);
      packet_bytes.push_back(rae_pkg::ATTR_CALLING_ID);
      packet_bytes.push_back(rae_pkg::LEN_MAC);
      for (int i = 0; i < 6; i++) packet_bytes.push_back(mac_text[i]);
      send_packet();

      // Framed IP and a minimal endpoint that end exactly with the packet.
      add_header(1'b0);
      add_attr(rae_pkg::ATTR_FRAMED_IP, rae_pkg::LEN_FRAMED_IP);
      add_attr(rae_pkg::ATTR_ENDPOINT, rae_pkg::LEN_MIN);
      send_packet();

      drain();

      // Random packets until enough input words have been sent.
      parsed = 0;
      while (parsed < PARSED_TARGET) begin
         build_random_packet();
         parsed += packet_bytes.size();
         no_gaps = $urandom_range(0, 3) == 0;
         send_packet();
         if ($urandom_range(0, 7) == 0) drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("** radius_attribute_extractor_top: PASSED **");
      end else begin
         $display("** radius_attribute_extractor_top: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
rtl/rae_pkg.sv
rtl/rae_front.sv
rtl/rae_fifo.sv
rtl/rae_back.sv
rtl/radius_attribute_extractor_top.sv
rtl/rae_checker.sv
test/radius_attribute_extractor_top_tb.sv
